@@ rtl/open_address_int_hash_table_assert.svh @@
// Assertion macros for the hash table RTL.
// Used by files that carry concurrent checks; depends on nothing.
`ifndef OPEN_ADDRESS_INT_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_INT_HASH_TABLE_ASSERT_SVH
// implication checked at every edge out of reset
`define OAH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define OAH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/oaht_pkg.sv @@
// Shared types and constants for the open-address hash table.
// No dependencies.
package oaht_pkg;
  localparam int IndexBitsDef  = 8;
  localparam int TableDepthDef = 256;
  localparam int ProbeLimitDef = 256;
  localparam logic [63:0] MultReset  = 64'd11400714819323198485;
  localparam logic [7:0]  LimitReset = 8'd180;

  typedef enum logic [1:0] {
    MODE_GET = 2'd0, MODE_SET = 2'd1, MODE_DEL = 2'd2, MODE_NOP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ABSENT = 2'd1, ST_FULL = 2'd2, ST_PROBE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FLAG_EMPTY = 2'd0, FLAG_LIVE = 2'd1, FLAG_TOMB = 2'd2, FLAG_RSVD = 2'd3
  } flag_t;

  localparam logic CFG_MULT  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  // queued operation between front and back
  typedef struct packed {
    mode_t       mode;
    logic [63:0] key;
    logic [63:0] value;
  } op_t;

  // completed result
  typedef struct packed {
    logic        found;
    logic [63:0] read_value;
    status_t     status;
    logic [8:0]  live_count;
  } res_t;
endpackage

@@ rtl/open_address_int_hash_table.sv @@
// Top level of the open-address integer hash table.
// Depends on oaht_pkg, oaht_front and oaht_back.
//
// Hash map from 64-bit keys to 64-bit values with get, set and delete.
// Operations enter a two-entry queue (push/full) and results leave through
// a one-entry output register (empty/pop). The back end takes one operation
// at a time and forms every 64-bit product with a single 32x32 multiplier
// over several cycles. The first probe runs the hash multiply, one memory
// read and one evaluate after the take; each further probe first forms
// k*k+k+3, then hashes, reads and evaluates. A no-op answers the cycle
// after it is taken. The next operation is taken only after the result has
// been popped, so operations never overlap. After reset a flag clear sweep
// over all TableDepth slots runs before the first operation is taken;
// configuration writes are taken at any time and belong between operations.
module open_address_int_hash_table #(
  parameter int IndexBits  = oaht_pkg::IndexBitsDef,
  parameter int TableDepth = oaht_pkg::TableDepthDef,
  parameter int ProbeLimit = oaht_pkg::ProbeLimitDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic signed [63:0] key,
  input  logic signed [63:0] value,
  output logic        empty,
  input  logic        pop,
  output logic        found,
  output logic signed [63:0] read_value,
  output logic [1:0]  status,
  output logic [8:0]  live_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import oaht_pkg::*;

  logic [63:0] mult;
  logic [7:0]  limit;
  op_t  op_in, op_q;
  res_t res;
  logic avail, take, res_valid;

  assign cfg_ready = 1'b1;
  // hold configuration; force the multiplier odd
  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= MultReset; limit <= LimitReset;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MULT) mult <= cfg_data | 64'd1;
      else limit <= cfg_data[7:0];
    end
  end

  assign op_in = '{mode: mode_t'(mode), key: key, value: value};

  oaht_front u_front (
    .clk, .rst, .push, .full, .op_in, .take, .avail, .op_out(op_q)
  );

  oaht_back #(.IndexBits(IndexBits), .TableDepth(TableDepth),
              .ProbeLimit(ProbeLimit)) u_back (
    .clk, .rst, .avail, .op(op_q), .take, .mult, .limit,
    .res_valid, .res, .res_pop(pop)
  );

  assign empty      = !res_valid;
  assign found      = res.found;
  assign read_value = res.read_value;
  assign status     = res.status;
  assign live_count = res.live_count;
endmodule

@@ rtl/oaht_front.sv @@
// Front end: accepts operations into a short queue.
// Depends on oaht_pkg.
module oaht_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  oaht_pkg::op_t  op_in,
  input  logic           take,
  output logic           avail,
  output oaht_pkg::op_t  op_out
);
  import oaht_pkg::*;
  localparam int Depth = 2;

  op_t        q [Depth];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_push, do_take;

  assign full    = (cnt == 2'd2);
  assign avail   = (cnt != 2'd0);
  assign do_push = push && !full;
  assign do_take = take && avail;
  assign op_out  = q[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_take) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_take};
    end
  end
endmodule

@@ rtl/oaht_back.sv @@
// Back end: probe sequencer over the slot memories, flag clear sweep.
// Depends on oaht_pkg and the assertion macro header.
module oaht_back #(
  parameter int IndexBits  = oaht_pkg::IndexBitsDef,
  parameter int TableDepth = oaht_pkg::TableDepthDef,
  parameter int ProbeLimit = oaht_pkg::ProbeLimitDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  oaht_pkg::op_t  op,
  output logic           take,
  input  logic [63:0]    mult,
  input  logic [7:0]     limit,
  output logic           res_valid,
  output oaht_pkg::res_t res,
  input  logic           res_pop
);
  import oaht_pkg::*;
  `include "open_address_int_hash_table_assert.svh"

  localparam int AW = $clog2(TableDepth);
  localparam int PW = $clog2(ProbeLimit + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_MUL = 6'b000100,
    S_READ  = 6'b001000, S_EVAL = 6'b010000, S_SQ  = 6'b100000
  } state_t;

  state_t        state;
  logic [63:0]   slot_keys   [TableDepth];
  logic [63:0]   slot_values [TableDepth];
  logic [1:0]    slot_flags  [TableDepth];

  op_t           cur;
  logic [63:0]   pk, prod;
  logic [AW-1:0] addr, tomb, clr;
  logic          tomb_seen;
  logic [PW-1:0] nprobe;
  logic [63:0]   rd_key, rd_val;
  logic [1:0]    rd_flag;
  logic [8:0]    count, cnt_next;
  logic          out_full;
  logic [AW-1:0] hidx;
  // shared 32x32 multiplier, stepped over several cycles
  logic [1:0]    mstep;
  logic [63:0]   macc, mb, mp, mres;
  logic [31:0]   mx, my;
  // evaluate stage
  logic          hit, is_empty, is_tomb, last, room, fin, ins_ok, res_set;
  logic [AW-1:0] ins_addr;
  logic [63:0]   r_value;
  status_t       r_status;
  logic          wr_en, wr_data_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_flag;

  assign hidx      = AW'(prod[63 -: IndexBits]);
  assign take      = (state == S_IDLE) && avail && !out_full;
  assign res_valid = out_full;

  // memories; read data lines up with addr in the evaluate cycle
  always_ff @(posedge clk) begin
    rd_key  <= slot_keys[hidx];
    rd_val  <= slot_values[hidx];
    rd_flag <= slot_flags[hidx];
    if (wr_en) begin
      slot_flags[wr_addr] <= wr_flag;
      if (wr_data_en) begin
        slot_keys[wr_addr]   <= cur.key;
        slot_values[wr_addr] <= cur.value;
      end
    end
  end

  // low 64 bits of pk * mb from three 32x32 partial products
  always_comb begin
    mb = (state == S_SQ) ? pk : mult;
    case (mstep)
      2'd0: begin
        mx = pk[31:0];  my = mb[31:0];
      end
      2'd1: begin
        mx = pk[31:0];  my = mb[63:32];
      end
      default: begin
        mx = pk[63:32]; my = mb[31:0];
      end
    endcase
    mp   = {32'd0, mx} * {32'd0, my};
    mres = {macc[63:32] + mp[31:0], macc[31:0]};
  end

  // evaluate one probe: result fields, count and memory write; also the clear sweep write
  always_comb begin
    hit      = (rd_flag == FLAG_LIVE) && (rd_key == cur.key);
    is_empty = (rd_flag == FLAG_EMPTY);
    is_tomb  = (rd_flag == FLAG_TOMB);
    last     = (nprobe == PW'(ProbeLimit - 1));
    room     = ({1'b0, limit} > count);
    fin      = hit || is_empty || last;
    ins_ok   = is_empty || (last && (tomb_seen || is_tomb));
    // new key goes to the latest tombstone passed, else the empty slot
    if (is_empty) ins_addr = tomb_seen ? tomb : addr;
    else ins_addr = is_tomb ? addr : tomb;
    r_value  = 64'd0;
    r_status = ST_OK;
    cnt_next = count;
    wr_en = 1'b0; wr_addr = addr; wr_data_en = 1'b0; wr_flag = FLAG_EMPTY;
    if (state == S_CLEAR) begin
      wr_en = 1'b1; wr_addr = clr;
    end else if (state == S_EVAL) begin
      if (hit) begin
        case (cur.mode)
          MODE_GET: r_value = rd_val;
          MODE_SET: begin
            wr_en = 1'b1; wr_data_en = 1'b1; wr_flag = FLAG_LIVE;
          end
          MODE_DEL: begin
            wr_en = 1'b1; wr_flag = FLAG_TOMB;
            if (count != 9'd0) cnt_next = count - 9'd1;
          end
          default: r_value = 64'd0;
        endcase
      end else if (fin) begin
        if (cur.mode == MODE_SET) begin
          if (!room) begin
            r_status = ST_FULL;
          end else if (ins_ok) begin
            wr_en = 1'b1; wr_data_en = 1'b1; wr_flag = FLAG_LIVE;
            wr_addr = ins_addr;
            cnt_next = count + 9'd1;
          end else begin
            r_status = ST_PROBE;
          end
        end else begin
          r_status = is_empty ? ST_ABSENT : ST_PROBE;
        end
      end
    end
    res_set = ((state == S_EVAL) && fin) || (take && op.mode == MODE_NOP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr <= '0; count <= '0; out_full <= 1'b0; mstep <= 2'd0;
    end else begin
      if (res_set) out_full <= 1'b1;
      else if (res_pop && out_full) out_full <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(TableDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (take) begin
            cur <= op; pk <= op.key; nprobe <= '0; tomb_seen <= 1'b0;
            if (op.mode == MODE_NOP) begin
              res <= '{found: 1'b0, read_value: 64'd0, status: ST_OK,
                       live_count: count};
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          case (mstep)
            2'd0: begin
              macc <= mp; mstep <= 2'd1;
            end
            2'd1: begin
              macc <= mres; mstep <= 2'd2;
            end
            default: begin
              prod <= mres; mstep <= 2'd0; state <= S_READ;
            end
          endcase
        end
        S_READ: begin
          addr  <= hidx;
          state <= S_EVAL;
        end
        S_EVAL: begin
          count <= cnt_next;
          if (fin) begin
            res <= '{found: hit, read_value: r_value, status: r_status,
                     live_count: cnt_next};
            state <= S_IDLE;
          end else begin
            if (is_tomb) begin
              tomb_seen <= 1'b1; tomb <= addr;
            end
            nprobe <= nprobe + PW'(1);
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          // rekey: pk*pk over three steps, then add pk + 3 and rehash
          case (mstep)
            2'd0: begin
              macc <= mp; mstep <= 2'd1;
            end
            2'd1: begin
              macc <= mres; mstep <= 2'd2;
            end
            2'd2: begin
              macc <= mres; mstep <= 2'd3;
            end
            default: begin
              pk <= macc + pk + 64'd3; mstep <= 2'd0; state <= S_MUL;
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OAH_ASSERT_IMP(a_take_idle, clk, rst, take, state == S_IDLE)
  `OAH_ASSERT_IMP(a_no_take_full, clk, rst, take, !out_full)
  `OAH_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= 9'(TableDepth))
endmodule

@@ tb/sv/oaht_checker.sv @@
// Scoreboard for the open-address hash table: watches the op, result and config channels.
// Keeps its own copy of the table, predicts each result and compares it; needs oaht_pkg.
`timescale 1ns / 1ps
module oaht_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         mode,
  input  logic signed [63:0] key,
  input  logic signed [63:0] value,
  input  logic               empty,
  input  logic               pop,
  input  logic               found,
  input  logic signed [63:0] read_value,
  input  logic [1:0]         status,
  input  logic [8:0]         live_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 errors,
  output int                 outstanding
);
  import oaht_pkg::*;

  localparam int Depth    = TableDepthDef;
  localparam int MaxProbe = ProbeLimitDef;

  flag_t       tbl_flag [Depth];
  logic [63:0] tbl_key  [Depth];
  logic [63:0] tbl_val  [Depth];
  int          live_entries;
  logic [63:0] mult;
  logic [7:0]  limit;
  res_t        pending_results [$];

  function automatic int home_slot(logic [63:0] k);
    logic [63:0] prod;
    prod = k * mult;
    return int'(prod[63:64-IndexBitsDef]) % Depth;
  endfunction

  // Walk the probe chain and apply one operation to the table copy.
  function automatic res_t apply_op(logic [1:0] m, logic [63:0] k, logic [63:0] v);
    logic [63:0] pk;
    int s, hit_slot, empty_slot, tomb_slot;
    bit hit, empty_seen, tomb_seen;
    res_t r;
    r = '0;
    r.status = ST_OK;
    hit = 0; empty_seen = 0; tomb_seen = 0;
    hit_slot = 0; empty_slot = 0; tomb_slot = 0;
    pk = k;
    if (mode_t'(m) != MODE_NOP) begin
      for (int n = 0; n < MaxProbe; n++) begin
        s = home_slot(pk);
        if (tbl_flag[s] == FLAG_EMPTY) begin
          empty_seen = 1;
          empty_slot = s;
          break;
        end
        if (tbl_flag[s] == FLAG_LIVE && tbl_key[s] == k) begin
          hit = 1;
          hit_slot = s;
          break;
        end
        if (tbl_flag[s] == FLAG_TOMB) begin
          tomb_seen = 1;
          tomb_slot = s;
        end
        pk = pk * pk + pk + 64'd3;
      end
      r.found = hit;
      case (mode_t'(m))
        MODE_GET: begin
          if (hit) r.read_value = tbl_val[hit_slot];
          else r.status = empty_seen ? ST_ABSENT : ST_PROBE;
        end
        MODE_SET: begin
          if (hit) begin
            tbl_val[hit_slot] = v;
          end else if (live_entries >= int'(limit)) begin
            r.status = ST_FULL;
          end else if (tomb_seen || empty_seen) begin
            s = tomb_seen ? tomb_slot : empty_slot;
            tbl_key[s]  = k;
            tbl_val[s]  = v;
            tbl_flag[s] = FLAG_LIVE;
            live_entries++;
          end else begin
            r.status = ST_PROBE;
          end
        end
        default: begin
          if (hit) begin
            tbl_flag[hit_slot] = FLAG_TOMB;
            if (live_entries > 0) live_entries--;
          end else begin
            r.status = empty_seen ? ST_ABSENT : ST_PROBE;
          end
        end
      endcase
    end
    r.live_count = live_entries[8:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      foreach (tbl_flag[i]) tbl_flag[i] = FLAG_EMPTY;
      live_entries = 0;
      mult  = MultReset;
      limit = LimitReset;
      pending_results.delete();
    end else begin
      if (!empty && pop) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", {63'd0, found}, 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (found !== want.found) report("found", {63'd0, found}, {63'd0, want.found});
          if (read_value !== want.read_value) report("read_value", read_value, want.read_value);
          if (status !== want.status) report("status", {62'd0, status}, {62'd0, want.status});
          if (live_count !== want.live_count)
            report("live_count", {55'd0, live_count}, {55'd0, want.live_count});
        end
      end
      if (cfg_valid && cfg_ready) begin
        // an even multiplier is forced odd
        if (cfg_index == CFG_MULT) mult = cfg_data | 64'd1;
        else limit = cfg_data[7:0];
      end
      if (push && !full) pending_results.push_back(apply_op(mode, key, value));
    end
    outstanding = pending_results.size();
  end
endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for open_address_int_hash_table: clock, reset, stimulus and verdict.
// Depends on oaht_pkg, the RTL and oaht_checker, which does all prediction and checking.
`timescale 1ns / 1ps
module tb_top;
  import oaht_pkg::*;

  localparam longint CycleLimit = 20000000;
  localparam logic [63:0] KeyMin  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KeyTop  = 64'h7FFF_FFFF_FFFF_FFFD;
  localparam logic [63:0] KeyRsvA = 64'h7FFF_FFFF_FFFF_FFFE;
  localparam logic [63:0] KeyRsvB = 64'h7FFF_FFFF_FFFF_FFFF;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [1:0]         mode;
  logic signed [63:0] key;
  logic signed [63:0] value;
  logic               empty;
  logic               pop;
  logic               found;
  logic signed [63:0] read_value;
  logic [1:0]         status;
  logic [8:0]         live_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [63:0]        cfg_data;
  int                 errors;
  int                 outstanding;

  // receiver controls: a long hold-off request and the quiet tail of the run
  bit                 hold_req;
  bit                 quiet;
  longint             cycles;
  logic [63:0]        key_pool [128];

  open_address_int_hash_table DUT (.*);

  oaht_checker u_checker (.*);

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a run that outlives a generous total budget is a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one operation; push stays high so back-to-back transactions need no gap.
  task automatic send(mode_t m, logic [63:0] k, logic [63:0] v);
    push  <= 1'b1;
    mode  <= m;
    key   <= k;
    value <= v;
    do @(posedge clk); while (full);
  endtask

  // Occasionally drop push for a short burst.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Let the checker see the last transaction before trusting its count.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write a register only once the table is idle; every op yields a result,
  // so a short settle after the last one is enough.
  task automatic cfg_write(logic idx, logic [63:0] data);
    drain();
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic over a key pool so that sets, hits and deletes meet.
  task automatic random_phase(int n_items, int pool_size, bit do_hold, bit do_pause);
    int r;
    logic [63:0] k;
    for (int i = 0; i < pool_size; i++) key_pool[i] = rand64();
    for (int i = 0; i < n_items; i++) begin
      if (do_hold && i == n_items / 3) hold_req = 1'b1;
      if (do_pause && i == n_items / 2) drain();
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, pool_size - 1)];
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 4))
          0: k = KeyMin;
          1: k = KeyTop;
          2: k = KeyRsvA;
          3: k = KeyRsvB;
          default: k = rand64();
        endcase
      end
      if (r < 45) send(MODE_SET, k, rand64());
      else if (r < 75) send(MODE_GET, k, rand64());
      else if (r < 96) send(MODE_DEL, k, rand64());
      else send(MODE_NOP, k, rand64());
      sender_gap();
    end
  endtask

  // Receiver: pop with random stall bursts, one long hold-off on request.
  initial begin
    pop = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    mode      = MODE_GET;
    key       = '0;
    value     = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MULT;
    cfg_data  = '0;
    hold_req  = 1'b0;
    quiet     = 1'b0;
    cycles    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme keys, reserved top keys, replace, tombstone reuse, nop.
    send(MODE_GET, KeyMin, 64'd0);
    send(MODE_SET, KeyMin, 64'h7FFF_FFFF_FFFF_FFFF);
    send(MODE_GET, KeyMin, 64'd0);
    send(MODE_SET, KeyMin, 64'h8000_0000_0000_0000);
    send(MODE_SET, 64'd0, 64'd0);
    send(MODE_SET, '1, '1);
    send(MODE_SET, KeyRsvA, 64'h5555_AAAA_5555_AAAA);
    send(MODE_SET, KeyRsvB, 64'hAAAA_5555_AAAA_5555);
    send(MODE_GET, KeyRsvB, '1);
    send(MODE_DEL, KeyRsvA, '1);
    send(MODE_GET, KeyRsvA, 64'd0);
    send(MODE_DEL, KeyRsvA, 64'd0);
    send(MODE_SET, KeyRsvA, 64'd7);
    send(MODE_NOP, KeyRsvA, '1);
    send(MODE_GET, KeyTop, 64'd0);
    send(MODE_GET, 64'd0, 64'd0);

    // Limit below the live count: new keys refused, existing keys still updated.
    cfg_write(CFG_LIMIT, 64'd1);
    send(MODE_SET, KeyTop, 64'd9);
    send(MODE_SET, 64'd0, 64'd11);
    send(MODE_DEL, '1, 64'd0);

    // Even multiplier is made odd; widest limit.
    cfg_write(CFG_MULT, 64'd2);
    cfg_write(CFG_LIMIT, 64'd255);
    send(MODE_SET, KeyTop, 64'd1);
    send(MODE_GET, KeyTop, 64'd0);
    send(MODE_GET, KeyMin, 64'd0);
    send(MODE_DEL, 64'd0, 64'd0);

    // Random phases, each under its own register setting.
    cfg_write(CFG_MULT, MultReset);
    cfg_write(CFG_LIMIT, 64'(LimitReset));
    random_phase(460, 100, 1'b1, 1'b0);
    cfg_write(CFG_MULT, 64'd1);
    cfg_write(CFG_LIMIT, 64'd40);
    random_phase(460, 80, 1'b0, 1'b1);
    cfg_write(CFG_MULT, '1);
    cfg_write(CFG_LIMIT, 64'd255);
    random_phase(460, 120, 1'b0, 1'b0);
    cfg_write(CFG_MULT, rand64() & ~64'd1);
    cfg_write(CFG_LIMIT, 64'($urandom_range(1, 254)));
    quiet = 1'b1;
    random_phase(440, 64, 1'b0, 1'b0);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/oaht_pkg.sv
rtl/oaht_front.sv
rtl/oaht_back.sv
rtl/open_address_int_hash_table.sv
tb/sv/oaht_checker.sv
tb/sv/tb_top.sv
